### hdl/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg
// Types and constants shared by the ASCII integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

    localparam int unsigned ValueWidth = 64;
    localparam int unsigned BaseWidth  = 5;
    localparam int unsigned CountWidth = 8;

    // parse_mode codes
    localparam logic [1:0] MODE_AUTO     = 2'd0;
    localparam logic [1:0] MODE_UNSIGNED = 2'd1;
    localparam logic [1:0] MODE_SIGNED   = 2'd2;

    // register indexes (byte address = 8 * index)
    localparam logic [1:0] REG_PARSE_MODE = 2'd0;
    localparam logic [1:0] REG_FIXED_BASE = 2'd1;
    localparam logic [1:0] REG_MAX_VALUE  = 2'd2;

    // radix values
    localparam logic [BaseWidth-1:0] BASE_MIN = 5'd2;
    localparam logic [BaseWidth-1:0] BASE_OCT = 5'd8;
    localparam logic [BaseWidth-1:0] BASE_DEC = 5'd10;
    localparam logic [BaseWidth-1:0] BASE_MAX = 5'd16;

    // characters
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
    localparam logic [7:0] CH_LZ    = 8'h7a;  // 'z'
    localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
    localparam logic [7:0] CH_UZ    = 8'h5a;  // 'Z'
    localparam logic [7:0] CH_LX    = 8'h78;  // 'x'
    localparam logic [7:0] CH_UX    = 8'h58;  // 'X'
    localparam logic [7:0] CH_LB    = 8'h62;  // 'b'
    localparam logic [7:0] CH_UB    = 8'h42;  // 'B'
    localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'
    localparam logic [7:0] CH_PLUS  = 8'h2b;  // '+'

    localparam logic [5:0] DIGIT_NONE = 6'h3f;

    typedef enum logic [2:0] {
        PH_SIGN   = 3'd0,
        PH_PEEK   = 3'd1,
        PH_ZERO   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       new_string;
    } in_word_t;

    typedef struct packed {
        logic [ValueWidth-1:0] value_bits;
        logic                  finished;
        logic [CountWidth-1:0] chars_consumed;
    } out_word_t;

endpackage

### hdl/ascii_integer_parser.sv
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Streams ASCII bytes in and returns the running integer value per byte.
// ----------------------------------------------------------------------------
// One byte is accepted per clock while out_stall is low, and every byte yields
// one result word that reaches the output through the input register, then
// the result register. The clock
// rate is set by the accumulator loop: a 64 x 5 bit multiply by the radix,
// the digit add and the compare against max_value sit between the input
// register and the state/result registers. Registers sit at byte address
// 8 * index on a 64-bit APB port: parse_mode at 0x00, fixed_base at 0x08,
// max_value at 0x10. Write configuration only while the block is idle.
module ascii_integer_parser
    import aip_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    // byte stream in
    input  logic            in_valid,
    output logic            in_stall,
    input  in_word_t        in_data,
    // results out
    output logic            out_valid,
    input  logic            out_stall,
    output out_word_t       out_data,
    // APB
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [63:0]     pwdata,
    output logic [63:0]     prdata,
    output logic            pready
);

    // ---------------- configuration ----------------
    logic [1:0]            parse_mode_reg;
    logic [BaseWidth-1:0]  fixed_base_reg;
    logic [ValueWidth-1:0] max_value_reg;
    logic                  cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_mode_reg <= MODE_AUTO;
            fixed_base_reg <= BASE_DEC;
            max_value_reg  <= '1;
        end
        else if (cfg_write)
        begin
            case (paddr[4:3])
                REG_PARSE_MODE: parse_mode_reg <= pwdata[1:0];
                REG_FIXED_BASE: fixed_base_reg <= pwdata[BaseWidth-1:0];
                REG_MAX_VALUE:  max_value_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            REG_PARSE_MODE: prdata = {62'd0, parse_mode_reg};
            REG_FIXED_BASE: prdata = {{(64-BaseWidth){1'b0}}, fixed_base_reg};
            REG_MAX_VALUE:  prdata = max_value_reg;
            default:        prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    logic     in_valid_reg;
    in_word_t in_word_reg;
    logic     out_valid_reg;
    logic     out_load;

    // result register frees up when empty or being taken
    assign out_load = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_word_reg <= in_data;
        end
    end

    // ---------------- parse state ----------------
    logic [ValueWidth-1:0] acc_reg, acc_next;
    phase_t                phase_reg, phase_next;
    logic                  neg_reg, neg_next;
    logic [BaseWidth-1:0]  base_reg, base_next;
    logic [CountWidth-1:0] count_reg, count_next;
    logic                  fin_next;

    logic [BaseWidth-1:0]  clamp_base;
    logic [7:0]            ch;
    logic [5:0]            digit;
    logic [BaseWidth-1:0]  dig_base;
    logic [ValueWidth+5:0] candidate;
    logic                  take;
    logic                  live;

    assign ch = in_word_reg.char_code;

    always_comb
    begin
        if (fixed_base_reg < BASE_MIN)
            clamp_base = BASE_MIN;
        else if (fixed_base_reg > BASE_MAX)
            clamp_base = BASE_MAX;
        else
            clamp_base = fixed_base_reg;
    end

    always_comb
    begin
        if (ch >= CH_ZERO && ch <= CH_NINE)
            digit = 6'(ch - CH_ZERO);
        else if (ch >= CH_LA && ch <= CH_LZ)
            digit = 6'(ch - CH_LA + 8'd10);
        else if (ch >= CH_UA && ch <= CH_UZ)
            digit = 6'(ch - CH_UA + 8'd10);
        else
            digit = DIGIT_NONE;
    end

    // phases only move forward, so a byte that is passed on without being
    // taken falls into the next section below
    always_comb
    begin
        acc_next   = acc_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        base_next  = base_reg;
        count_next = count_reg;
        fin_next   = 1'b0;
        take       = 1'b0;
        live       = 1'b1;
        dig_base   = BASE_MIN;
        candidate  = '0;

        if (in_word_reg.new_string)
        begin
            acc_next   = '0;
            neg_next   = 1'b0;
            count_next = '0;
            if (parse_mode_reg == MODE_UNSIGNED)
            begin
                base_next  = clamp_base;
                phase_next = PH_DIGITS;
            end
            else
            begin
                base_next  = BASE_DEC;
                phase_next = PH_SIGN;
            end
        end

        if (live && phase_next == PH_SIGN)
        begin
            if (parse_mode_reg != MODE_UNSIGNED && (ch == CH_MINUS || ch == CH_PLUS))
            begin
                if (ch == CH_MINUS)
                    neg_next = 1'b1;
                take = 1'b1;
                live = 1'b0;
            end
            if (parse_mode_reg == MODE_UNSIGNED || parse_mode_reg == MODE_SIGNED)
            begin
                base_next  = clamp_base;
                phase_next = PH_DIGITS;
            end
            else
            begin
                phase_next = PH_PEEK;
            end
        end

        if (live && phase_next == PH_PEEK)
        begin
            if (ch == CH_ZERO)
            begin
                take       = 1'b1;
                live       = 1'b0;
                base_next  = BASE_OCT;
                phase_next = PH_ZERO;
            end
            else
            begin
                base_next  = BASE_DEC;
                phase_next = PH_DIGITS;
            end
        end

        if (live && phase_next == PH_ZERO)
        begin
            phase_next = PH_DIGITS;
            if (ch == CH_LX || ch == CH_UX)
            begin
                base_next = BASE_MAX;
                take      = 1'b1;
                live      = 1'b0;
            end
            else if (ch == CH_LB || ch == CH_UB)
            begin
                base_next = BASE_MIN;
                take      = 1'b1;
                live      = 1'b0;
            end
            else
            begin
                base_next = BASE_OCT;
            end
        end

        if (live && phase_next == PH_DIGITS)
        begin
            if (base_next < BASE_MIN)
                dig_base = BASE_MIN;
            else if (base_next > BASE_MAX)
                dig_base = BASE_MAX;
            else
                dig_base = base_next;
            // acc*b + d <= max  is the same test as  acc <= (max - d) / b
            candidate = (ValueWidth+6)'(acc_next * dig_base)
                      + (ValueWidth+6)'(digit);
            if ({1'b0, digit} < {1'b0, dig_base}
                && candidate <= (ValueWidth+6)'(max_value_reg))
            begin
                acc_next = candidate[ValueWidth-1:0];
                take     = 1'b1;
            end
            else
            begin
                fin_next   = 1'b1;
                phase_next = PH_DONE;
            end
        end

        if (take && count_next != '1)
            count_next = count_next + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            phase_reg <= PH_SIGN;
            neg_reg   <= 1'b0;
            base_reg  <= BASE_DEC;
            count_reg <= '0;
        end
        else if (out_load)
        begin
            acc_reg   <= acc_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            base_reg  <= base_next;
            count_reg <= count_next;
        end
    end

    // ---------------- result register ----------------
    logic [ValueWidth-1:0] mag_out_reg;
    logic                  neg_out_reg;
    logic                  fin_out_reg;
    logic [CountWidth-1:0] count_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            mag_out_reg   <= acc_next;
            neg_out_reg   <= neg_next;
            fin_out_reg   <= fin_next;
            count_out_reg <= count_next;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        out_data.value_bits     = neg_out_reg ? (ValueWidth)'(0) - mag_out_reg : mag_out_reg;
        out_data.finished       = fin_out_reg;
        out_data.chars_consumed = count_out_reg;
    end

endmodule
